[hdl/alias_table_sampler_assert.svh]
// Assertion macros for the alias table sampler.
// No dependencies; included by the top level.
`ifndef ALIAS_TABLE_SAMPLER_ASSERT_SVH
`define ALIAS_TABLE_SAMPLER_ASSERT_SVH
// Check that a property holds after reset.
`define ATS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Check that a condition never occurs after reset.
`define ATS_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`endif

[hdl/ats_pkg.sv]
// Package for the alias table sampler: codes, command and status types.
// No dependencies.
package ats_pkg;
  localparam int MAX_CATEGORIES = 64;
  localparam logic [2:0] KIND_LOAD = 3'd0;
  localparam logic [2:0] KIND_BUILD = 3'd1;
  localparam logic [2:0] KIND_DRAW = 3'd2;
  localparam logic [2:0] KIND_MULTI = 3'd3;
  localparam logic [2:0] KIND_RESEED = 3'd4;
  localparam logic [1:0] CLS_DONE = 2'd0;
  localparam logic [1:0] CLS_LARGE = 2'd1;
  localparam logic [1:0] CLS_SMALL = 2'd2;
  localparam logic [31:0] LCG_MUL = 32'd69069;
  localparam logic [31:0] LCG_ZERO_SUB = 32'd12345671;
  localparam logic [31:0] SEED_RESET = 32'd1237;
  localparam logic CFG_NUM_CATEGORIES = 1'b0;
  localparam logic CFG_SEED = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_RESEED, OP_SCALE_RD, OP_SCALE_WR, OP_FIND, OP_PAIR_RD,
    OP_PAIR_WR, OP_CLR, OP_RAND, OP_MUL, OP_LOOK, OP_TALLY_RD, OP_TALLY_WR, OP_EMIT_RD,
    OP_INIT
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [9:0]  idx;
  } cmd_t;

  typedef struct packed {
    logic       found;
    logic [9:0] cnt_small;
  } sts_t;
endpackage

[hdl/ats_datapath.sv]
// Datapath of the alias table sampler: tables, generator, draw arithmetic.
// Depends on ats_pkg.
module ats_datapath import ats_pkg::*; #(
  parameter int FRACTION_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic [9:0]  ncat,
  input  logic [5:0]  in_index,
  input  logic [24:0] in_weight,
  input  logic [30:0] seed,
  output sts_t        sts,
  output logic [5:0]  res_cat,
  output logic [19:0] res_count
);
  localparam int AW = $clog2(MAX_CATEGORIES);
  localparam logic [31:0] ONE = 32'd1 << FRACTION_BITS;
  localparam logic [31:0] CMAX = 32'h7FFF_FFFF;

  logic [30:0] cutoff_mem [MAX_CATEGORIES];
  logic [AW-1:0] alias_mem [MAX_CATEGORIES];
  logic [1:0] cls_r [MAX_CATEGORIES];
  logic [19:0] tally_mem [MAX_CATEGORIES];

  logic [31:0] gen_r;
  logic [30:0] rd_r, rd2_r;
  logic [AW-1:0] j_r, k_r, al_r, pick_r;
  logic [41:0] prod_r;
  logic [19:0] tal_r;
  logic [9:0] nsmall_r;
  logic [AW-1:0] cur_r;
  logic [AW-1:0] cidx;

  logic [31:0] gen_nxt;
  logic [63:0] gmul;
  logic [41:0] scaled;
  logic [32:0] pair_sum;
  logic [31:0] prod_k;
  logic [AW-1:0] fj, fk;
  logic hj, hk;
  logic [39:0] fr_lim;
  logic take_alias;
  logic [AW-1:0] pick_sel;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] tal_addr;

  assign cidx = cmd.idx[AW-1:0];
  assign gmul = {32'd0, gen_r} * {32'd0, LCG_MUL} + 64'd1;
  assign gen_nxt = (gmul[31:0] == 32'd0) ? LCG_ZERO_SUB : gmul[31:0];
  assign scaled = {11'd0, rd_r} * {32'd0, ncat};
  assign pair_sum = {2'd0, rd_r} + {2'd0, rd2_r} - {1'b0, ONE};
  assign prod_k = prod_r[41:32] >= 10'(MAX_CATEGORIES) ? 32'(MAX_CATEGORIES - 1)
                                                        : {22'd0, prod_r[41:32]};
  assign fr_lim = {9'd0, rd_r} << (32 - FRACTION_BITS);

  // Fraction above the cutoff goes to the alias.
  assign take_alias = {8'd0, prod_r[31:0]} > fr_lim;
  assign pick_sel = take_alias ? al_r : pick_r;

  // Read addresses of the tables.
  always_comb begin
    case (cmd.op)
      OP_FIND: rd_addr = fj;
      OP_LOOK: rd_addr = AW'(prod_k);
      default: rd_addr = cidx;
    endcase
  end
  assign tal_addr = (cmd.op == OP_TALLY_RD) ? pick_sel : cidx;

  // Lowest small and lowest large cell among those in use.
  always_comb begin
    fj = '0; fk = '0; hj = 1'b0; hk = 1'b0;
    for (int i = MAX_CATEGORIES - 1; i >= 0; i--) begin
      if (10'(i) < ncat && cls_r[i] == CLS_SMALL) begin fj = AW'(i); hj = 1'b1; end
      if (10'(i) < ncat && cls_r[i] == CLS_LARGE) begin fk = AW'(i); hk = 1'b1; end
    end
  end

  assign sts.found = hj && hk;
  assign sts.cnt_small = nsmall_r;
  assign res_cat = 6'(cur_r);
  assign res_count = tal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= SEED_RESET;
      nsmall_r <= '0;
      for (int i = 0; i < MAX_CATEGORIES; i++) cls_r[i] <= CLS_DONE;
    end else begin
      unique case (cmd.op)
        OP_RESEED: gen_r <= {1'b0, seed};
        OP_SCALE_RD: if (cmd.idx == 10'd0) nsmall_r <= '0;
        OP_SCALE_WR: begin
          if ({1'b0, (scaled > 42'(CMAX)) ? CMAX[30:0] : scaled[30:0]} >= ONE) begin
            cls_r[cidx] <= CLS_LARGE;
          end else begin
            cls_r[cidx] <= CLS_SMALL;
            nsmall_r <= nsmall_r + 10'd1;
          end
        end
        OP_PAIR_WR: begin
          cls_r[j_r] <= CLS_DONE;
          if (pair_sum < {1'b0, ONE}) cls_r[k_r] <= CLS_SMALL;
          else nsmall_r <= nsmall_r - 10'd1;
        end
        OP_RAND: gen_r <= gen_nxt;
        default: ;
      endcase
    end
  end

  // Table storage and draw arithmetic.
  always_ff @(posedge clk) begin
    rd_r <= cutoff_mem[rd_addr];
    al_r <= alias_mem[rd_addr];
    tal_r <= tally_mem[tal_addr];
    cur_r <= (cmd.op == OP_EMIT_RD) ? pick_sel : cidx;
    if (cmd.op == OP_FIND) begin
      j_r <= fj;
      k_r <= fk;
      rd2_r <= cutoff_mem[fk];
    end
    if (cmd.op == OP_MUL) prod_r <= {10'd0, gen_r} * {32'd0, ncat};
    if (cmd.op == OP_LOOK) pick_r <= AW'(prod_k);
    else if (cmd.op == OP_TALLY_RD) pick_r <= pick_sel;
    unique case (cmd.op)
      OP_INIT: begin
        cutoff_mem[cidx] <= '0;
        alias_mem[cidx] <= cidx;
      end
      OP_LOAD: if (32'(in_index) < MAX_CATEGORIES) cutoff_mem[AW'(in_index)] <= 31'(in_weight);
      OP_SCALE_WR: begin
        cutoff_mem[cidx] <= (scaled > 42'(CMAX)) ? CMAX[30:0] : scaled[30:0];
        alias_mem[cidx] <= cidx;
      end
      OP_PAIR_WR: begin
        alias_mem[j_r] <= k_r;
        cutoff_mem[k_r] <= pair_sum > {1'b0, CMAX} ? CMAX[30:0] : pair_sum[30:0];
      end
      OP_CLR: tally_mem[cidx] <= '0;
      OP_TALLY_WR: tally_mem[pick_r] <= tal_r + 20'd1;
      default: ;
    endcase
  end
endmodule

[hdl/ats_ctrl.sv]
// Controller of the alias table sampler: sequences build, draws and output.
// Depends on ats_pkg.
module ats_ctrl import ats_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_kind,
  input  logic [19:0] in_draw_count,
  input  logic [9:0]  ncat,
  input  sts_t        sts,
  output cmd_t        cmd,
  output logic        res_load,
  output logic        res_last,
  output logic        res_multi,
  input  logic        out_free
);
  typedef enum logic [3:0] {
    S_IDLE, S_SCALE_RD, S_SCALE_WR, S_FIND, S_PAIR, S_CLR, S_RAND, S_MUL, S_LOOK,
    S_SEL, S_TALLY, S_EMIT_RD, S_EMIT, S_INIT
  } state_t;

  state_t state_r;
  logic [9:0] i_r;
  logic [19:0] left_r;
  logic multi_r;

  assign in_tready = (state_r == S_IDLE) && out_free;
  assign res_multi = multi_r;

  always_comb begin
    cmd.op = OP_NONE;
    cmd.idx = i_r;
    res_load = 1'b0;
    res_last = 1'b0;
    unique case (state_r)
      S_INIT: cmd.op = OP_INIT;
      S_IDLE: if (in_tvalid && in_tready) begin
        if (in_kind == KIND_LOAD) cmd.op = OP_LOAD;
        else if (in_kind == KIND_RESEED) cmd.op = OP_RESEED;
      end
      S_SCALE_RD: cmd.op = OP_SCALE_RD;
      S_SCALE_WR: cmd.op = OP_SCALE_WR;
      S_FIND: if (sts.cnt_small != 10'd0) cmd.op = OP_FIND;
      S_PAIR: cmd.op = OP_PAIR_WR;
      S_CLR: cmd.op = OP_CLR;
      S_RAND: cmd.op = OP_RAND;
      S_MUL: cmd.op = OP_MUL;
      S_LOOK: cmd.op = OP_LOOK;
      S_SEL: cmd.op = multi_r ? OP_TALLY_RD : OP_EMIT_RD;
      S_TALLY: cmd.op = OP_TALLY_WR;
      S_EMIT_RD: cmd.op = OP_NONE;
      S_EMIT: if (out_free) begin
        res_load = 1'b1;
        res_last = !multi_r || (i_r + 10'd1 == ncat);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      i_r <= '0;
      left_r <= '0;
      multi_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_INIT: if (i_r == 10'(MAX_CATEGORIES - 1)) begin
                  i_r <= '0;
                  state_r <= S_IDLE;
                end else i_r <= i_r + 10'd1;
        S_IDLE: if (in_tvalid && in_tready) begin
          i_r <= '0;
          left_r <= in_draw_count;
          multi_r <= (in_kind == KIND_MULTI);
          if (in_kind == KIND_BUILD) state_r <= S_SCALE_RD;
          else if (in_kind == KIND_DRAW) state_r <= S_RAND;
          else if (in_kind == KIND_MULTI) state_r <= S_CLR;
        end
        S_SCALE_RD: state_r <= S_SCALE_WR;
        S_SCALE_WR: if (i_r + 10'd1 == ncat) state_r <= S_FIND;
                    else begin i_r <= i_r + 10'd1; state_r <= S_SCALE_RD; end
        S_FIND: if (sts.cnt_small != 10'd0 && sts.found) state_r <= S_PAIR;
                else state_r <= S_IDLE;
        S_PAIR: state_r <= S_FIND;
        S_CLR: if (i_r == 10'(MAX_CATEGORIES - 1)) begin
                 i_r <= '0;
                 state_r <= (left_r == 20'd0) ? S_EMIT_RD : S_RAND;
               end else i_r <= i_r + 10'd1;
        S_RAND: state_r <= S_MUL;
        S_MUL: state_r <= S_LOOK;
        S_LOOK: state_r <= S_SEL;
        S_SEL: state_r <= multi_r ? S_TALLY : S_EMIT;
        S_TALLY: begin
          left_r <= left_r - 20'd1;
          state_r <= (left_r == 20'd1) ? S_EMIT_RD : S_RAND;
        end
        S_EMIT_RD: state_r <= S_EMIT;
        S_EMIT: if (out_free) begin
          if (!multi_r || i_r + 10'd1 == ncat) state_r <= S_IDLE;
          else begin i_r <= i_r + 10'd1; state_r <= S_EMIT_RD; end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[hdl/alias_table_sampler.sv]
// Top level of the alias table sampler: ports, config registers, output register.
// Depends on ats_pkg, ats_ctrl, ats_datapath and the assertion header.
`include "alias_table_sampler_assert.svh"
// Alias-method sampler over up to 64 categories with a 32-bit LCG source.
// After reset the core clears the cutoff and alias tables before it takes
// the first request. Requests: load weight, build, single draw, multinomial
// draw, reseed. Load and reseed complete as they are accepted. A build
// scales each cell (read, write), then pairs small with large cells (find,
// pair; at most ncat pairings) and ends with one closing check. A single
// draw steps through generate, multiply, lookup and select, and registers
// its result once the output register is free. A multinomial draw clears 64
// tallies, runs each sample through generate, multiply, lookup, select and
// tally, then emits ncat results (read, emit). One request is in work at a
// time; the output register frees the core as the result is taken.
module alias_table_sampler import ats_pkg::*; #(
  parameter int FRACTION_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // kind[2:0], index[8:3], weight[33:9], draw_count[53:34]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // category[5:0], count[25:6]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [30:0] cfg_data
);
  logic [6:0] ncfg_r;
  logic [30:0] seed_r;
  logic [9:0] ncat;
  cmd_t cmd;
  sts_t sts;
  logic res_load, res_last, res_multi;
  logic [5:0] res_cat;
  logic [19:0] res_count;
  logic out_free;

  assign cfg_ready = 1'b1;
  // Clamp the category count to 1..MAX_CATEGORIES and 64.
  always_comb begin
    ncat = {3'd0, ncfg_r};
    if (ncat == 10'd0) ncat = 10'd1;
    if (32'(ncat) > MAX_CATEGORIES) ncat = 10'(MAX_CATEGORIES);
    if (ncat > 10'd64) ncat = 10'd64;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncfg_r <= 7'd64;
      seed_r <= 31'd1237;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_NUM_CATEGORIES) ncfg_r <= cfg_data[6:0];
      else seed_r <= cfg_data;
    end
  end

  assign out_free = !out_tvalid || out_tready;

  ats_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_kind(in_tdata[2:0]), .in_draw_count(in_tdata[53:34]),
    .ncat, .sts, .cmd, .res_load, .res_last, .res_multi, .out_free
  );

  ats_datapath #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
    .clk, .rst_n, .cmd, .ncat, .in_index(in_tdata[8:3]), .in_weight(in_tdata[33:9]),
    .seed(seed_r), .sts, .res_cat, .res_count
  );

  // Hold the result until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (res_load) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_tdata <= {6'd0, res_multi ? res_count : 20'd0, res_cat};
      out_tlast <= res_last;
    end
  end

  `ATS_ASSERT(a_load_free, res_load |-> out_free)
  `ATS_ASSERT(a_hold_result, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
  `ATS_NEVER(a_ready_when_free, in_tready && out_tvalid && !out_tready)
  `ATS_ASSERT(a_single_last, (res_load && !res_multi) |-> res_last)
endmodule

[dv/ats_checker.sv]
// Checker for the alias table sampler: watches the request, result and register channels,
// predicts every result from its own copy of the sampler state and compares them in order.
// Depends on ats_pkg.
`timescale 1ns / 100ps

module ats_checker import ats_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [30:0] cfg_data,
  output int          mismatches,
  output int          outstanding,
  output int          results_seen
);

  localparam int          CELLS      = 64;
  localparam logic [63:0] ONE_FX     = 64'd1 << 24;
  localparam logic [63:0] CUTOFF_TOP = 64'h7FFF_FFFF;

  typedef struct packed {
    logic [5:0]  category;
    logic [19:0] count;
    logic        last;
  } sample_t;

  sample_t     sample_q[$];
  logic [31:0] lcg;
  logic [30:0] cutoff_mem[CELLS];
  logic [6:0]  alias_mem[CELLS];
  logic [1:0]  class_mem[CELLS];
  logic [19:0] tally_mem[CELLS];
  logic [6:0]  ncat_reg;
  logic [30:0] seed_reg;

  assign outstanding = sample_q.size();

  task automatic clear_state();
    sample_q.delete();
    lcg = SEED_RESET;
    for (int i = 0; i < CELLS; i++) begin
      cutoff_mem[i] = '0;
      alias_mem[i]  = 7'(i);
      class_mem[i]  = CLS_DONE;
      tally_mem[i]  = '0;
    end
    ncat_reg = 7'd64;
    seed_reg = 31'(SEED_RESET);
  endtask

  function automatic int unsigned cells_in_use();
    int unsigned n;
    n = ncat_reg;
    if (n == 0) n = 1;
    if (n > CELLS) n = CELLS;
    return n;
  endfunction

  function automatic logic [5:0] draw_cell(int unsigned n);
    logic [31:0] g;
    logic [63:0] prod;
    logic [31:0] k;
    g = lcg * LCG_MUL + 32'd1;
    if (g == 0) g = LCG_ZERO_SUB;
    lcg  = g;
    prod = {32'b0, g} * 64'(n);
    k    = prod[63:32];
    if (k >= CELLS) k = CELLS - 1;
    // fraction above the cutoff goes to the alias
    if ({32'b0, prod[31:0]} > ({33'b0, cutoff_mem[k]} << 8)) begin
      if (alias_mem[k] < CELLS) k = 32'(alias_mem[k]);
    end
    return k[5:0];
  endfunction

  task automatic build_cells(int unsigned n);
    int unsigned nsmall;
    int unsigned j;
    int unsigned k;
    logic [63:0] f;
    nsmall = 0;
    for (int unsigned i = 0; i < n; i++) begin
      f = 64'(cutoff_mem[i]) * 64'(n);
      alias_mem[i]  = 7'(i);
      cutoff_mem[i] = (f > CUTOFF_TOP) ? CUTOFF_TOP[30:0] : f[30:0];
      if (64'(cutoff_mem[i]) >= ONE_FX) begin
        class_mem[i] = CLS_LARGE;
      end else begin
        class_mem[i] = CLS_SMALL;
        nsmall++;
      end
    end
    while (nsmall > 0) begin
      for (j = 0; j < n; j++) if (class_mem[j] == CLS_SMALL) break;
      for (k = 0; k < n; k++) if (class_mem[k] == CLS_LARGE) break;
      if (j == n || k == n) break;
      alias_mem[j] = 7'(k);
      f = 64'(cutoff_mem[k]) + 64'(cutoff_mem[j]) - ONE_FX;
      cutoff_mem[k] = (f > CUTOFF_TOP) ? CUTOFF_TOP[30:0] : f[30:0];
      if (64'(cutoff_mem[k]) < ONE_FX) begin
        class_mem[k] = CLS_SMALL;
        nsmall++;
      end
      class_mem[j] = CLS_DONE;
      nsmall--;
    end
  endtask

  task automatic predict_request(logic [55:0] req);
    logic [2:0]  kind;
    logic [5:0]  idx;
    logic [24:0] weight;
    logic [19:0] draws;
    int unsigned n;
    logic [5:0]  pick;
    kind   = req[2:0];
    idx    = req[8:3];
    weight = req[33:9];
    draws  = req[53:34];
    n      = cells_in_use();
    case (kind)
      KIND_LOAD:   cutoff_mem[idx] = 31'(weight);
      KIND_BUILD:  build_cells(n);
      KIND_DRAW:   sample_q.push_back('{draw_cell(n), 20'd0, 1'b1});
      KIND_MULTI: begin
        for (int i = 0; i < CELLS; i++) tally_mem[i] = '0;
        for (int unsigned i = 0; i < draws; i++) begin
          pick = draw_cell(n);
          tally_mem[pick] = tally_mem[pick] + 20'd1;
        end
        for (int unsigned i = 0; i < n; i++)
          sample_q.push_back('{6'(i), tally_mem[i], i + 1 == n});
      end
      KIND_RESEED: lcg = {1'b0, seed_reg};
      default: ;
    endcase
  endtask

  task automatic compare_sample();
    sample_t want;
    if (sample_q.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result cat=%0d count=%0d last=%0b", $time,
               out_tdata[5:0], out_tdata[25:6], out_tlast);
      return;
    end
    want = sample_q.pop_front();
    if (out_tdata[5:0] !== want.category) begin
      mismatches++;
      $display("%0t: category expected %0d actual %0d", $time, want.category, out_tdata[5:0]);
    end
    if (out_tdata[25:6] !== want.count) begin
      mismatches++;
      $display("%0t: count expected %0d actual %0d (cat %0d)", $time, want.count,
               out_tdata[25:6], want.category);
    end
    if (out_tlast !== want.last) begin
      mismatches++;
      $display("%0t: last expected %0b actual %0b (cat %0d)", $time, want.last, out_tlast,
               want.category);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mismatches   = 0;
      results_seen = 0;
      clear_state();
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        compare_sample();
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_NUM_CATEGORIES) ncat_reg = cfg_data[6:0];
        else seed_reg = cfg_data;
      end
      if (in_tvalid && in_tready) predict_request(in_tdata);
    end
  end

endmodule

[dv/tb_alias_table_sampler.sv]
// Testbench top for the alias table sampler: clock, reset, request and register stimulus,
// result back-pressure and the verdict. Depends on ats_pkg, ats_checker and the sampler RTL.
`timescale 1ns / 100ps

module tb_alias_table_sampler import ats_pkg::*;;

  localparam logic [2:0]  KIND_TOP_CODE = 3'd7;
  localparam int          ITEM_TARGET   = 470;
  localparam int          SETTLE_CYCLES = 400;  // longest build plus margin
  localparam longint      CYCLE_LIMIT   = 20_000_000;
  localparam logic [24:0] WEIGHT_ONE    = 25'd1 << 24;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;   // kind[2:0], index[8:3], weight[33:9], draw_count[53:34]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // category[5:0], count[25:6]
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [30:0] cfg_data = '0;

  int     mismatches;
  int     outstanding;
  int     results_seen;
  int     requests_sent;
  int     phases;
  int     burst_left;
  longint cycles = 0;

  alias_table_sampler u_top (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  ats_checker u_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .outstanding, .results_seen
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop so a hung handshake cannot run forever.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, outstanding);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result back-pressure: switch stall patterns at the end of each random-length stretch,
  // including stretches where the receiver never stalls.
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned stall_tick = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(64, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      0: out_tready <= rst_n;
      1: out_tready <= rst_n && ($urandom_range(0, 3) != 0);
      2: out_tready <= rst_n && ($urandom_range(0, 7) == 0);
      default: out_tready <= rst_n && stall_tick[1];
    endcase
  end

  // Send one request; fields that this kind ignores carry random bits.
  task automatic send_request(logic [2:0] kind, logic [5:0] idx, logic [24:0] weight,
                              logic [19:0] draws);
    logic [5:0]  f_idx;
    logic [24:0] f_wt;
    logic [19:0] f_cnt;
    f_idx = (kind == KIND_LOAD) ? idx : 6'($urandom);
    f_wt  = (kind == KIND_LOAD) ? weight : 25'($urandom);
    f_cnt = (kind == KIND_MULTI) ? draws : 20'($urandom);
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, f_cnt, f_wt, f_idx, kind};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind <= KIND_RESEED) requests_sent++;
    // Close the burst with a gap; otherwise hold tvalid high for the next request.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Drain every owed result, then let a build that emits nothing finish.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [30:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Load a distribution over n cells whose weights sum to one.
  task automatic load_distribution(int unsigned n);
    int unsigned left;
    int unsigned w;
    left = WEIGHT_ONE;
    for (int unsigned i = 0; i < n; i++) begin
      if (i + 1 == n) begin
        w = left;
      end else begin
        w = $urandom_range(0, (2 * left) / (n - i));
        if (w > left) w = left;
      end
      left -= w;
      send_request(KIND_LOAD, 6'(i), 25'(w), '0);
    end
  endtask

  function automatic int unsigned pick_ncat();
    case ($urandom_range(0, 19))
      0: return 0;                       // zero is taken as one
      1: return $urandom_range(65, 127); // above the bound, clamped
      2: return 64;
      3: return 1;
      default: return $urandom_range(2, 12);
    endcase
  endfunction

  function automatic logic [19:0] pick_draws();
    if ($urandom_range(0, 24) == 0) return 20'($urandom_range(200, 600));
    return 20'($urandom_range(0, 40));
  endfunction

  initial begin
    int unsigned ncat;
    int unsigned used;
    requests_sent = 0;
    phases        = 0;
    burst_left    = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: draws from the reset table (no build, every cell maps to itself).
    send_request(KIND_DRAW, '0, '0, '0);
    send_request(KIND_MULTI, '0, '0, 20'd0);
    wait_idle();

    // Directed: small table with an uneven, non-normalized set of weights.
    write_reg(CFG_NUM_CATEGORIES, 31'd4);
    send_request(KIND_LOAD, 6'd0, WEIGHT_ONE, '0);
    send_request(KIND_LOAD, 6'd1, 25'd0, '0);
    send_request(KIND_LOAD, 6'd2, 25'h1FF_FFFF, '0);
    send_request(KIND_LOAD, 6'd3, 25'd0, '0);
    send_request(KIND_LOAD, 6'd63, 25'h1FF_FFFF, '0);
    send_request(KIND_BUILD, '0, '0, '0);
    send_request(KIND_DRAW, '0, '0, '0);
    send_request(KIND_MULTI, '0, '0, 20'd30);
    send_request(KIND_RESEED, '0, '0, '0);
    send_request(KIND_DRAW, '0, '0, '0);
    send_request(3'd5, '0, '0, '0);
    send_request(KIND_TOP_CODE, '0, '0, '0);
    wait_idle();

    // Directed: zero seed, largest seed, stale table after the count shrinks.
    write_reg(CFG_SEED, 31'd0);
    write_reg(CFG_NUM_CATEGORIES, 31'd2);
    send_request(KIND_RESEED, '0, '0, '0);
    send_request(KIND_DRAW, '0, '0, '0);
    send_request(KIND_MULTI, '0, '0, 20'd12);
    wait_idle();
    write_reg(CFG_SEED, 31'h7FFF_FFFF);
    write_reg(CFG_NUM_CATEGORIES, 31'd127);
    send_request(KIND_RESEED, '0, '0, '0);
    send_request(KIND_MULTI, '0, '0, 20'd5);
    wait_idle();

    // Random phases: new settings, mostly a well-formed load/build/draw sequence.
    while (requests_sent < ITEM_TARGET) begin
      phases++;
      ncat = pick_ncat();
      write_reg(CFG_NUM_CATEGORIES, 31'(ncat));
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0: write_reg(CFG_SEED, 31'd0);
          1: write_reg(CFG_SEED, 31'h7FFF_FFFF);
          default: write_reg(CFG_SEED, 31'($urandom));
        endcase
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          // Noise: any kind, any fields, short draw counts.
          repeat ($urandom_range(3, 12))
            send_request(3'($urandom_range(0, KIND_TOP_CODE)), 6'($urandom),
                         25'($urandom), 20'($urandom_range(0, 30)));
        end
        2: begin
          // Reuse the existing table under the new count.
          repeat ($urandom_range(2, 6))
            send_request($urandom_range(0, 1) ? KIND_DRAW : KIND_MULTI, '0, '0, pick_draws());
        end
        default: begin
          used = clamp_ncat(ncat);
          load_distribution(used);
          if ($urandom_range(0, 5) == 0)
            send_request(KIND_LOAD, 6'($urandom_range(0, 63)), 25'($urandom), '0);
          send_request(KIND_BUILD, '0, '0, '0);
          if ($urandom_range(0, 3) == 0) send_request(KIND_RESEED, '0, '0, '0);
          repeat ($urandom_range(2, 8))
            send_request($urandom_range(0, 2) ? KIND_DRAW : KIND_MULTI, '0, '0, pick_draws());
        end
      endcase
      wait_idle();
    end

    $display("covered %0d requests over %0d random phases, %0d results compared",
             requests_sent, phases, results_seen);
    $display("category counts 0..127 with clamping, zero and full-range seeds, stale tables");
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Effective category count for a raw register value.
  function automatic int unsigned clamp_ncat(int unsigned raw);
    int unsigned n;
    n = raw & 32'h7F;
    if (n == 0) n = 1;
    if (n > 64) n = 64;
    return n;
  endfunction

endmodule
